// File: rtl/assert_macros.svh
// Assertion macros shared by the tilt block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATPR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ATPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/atpr_pkg.sv
// Types, widths and the arctangent table for the tilt block.
package atpr_pkg;

  localparam int IN_W        = 16;               // raw sample width
  localparam int NUM_W       = IN_W + 1;         // negated sample needs one more bit
  localparam int OUT_W       = 16;               // angle word width
  localparam int ACC_FRAC    = 16;               // fraction bits of magnitude and angle sum
  localparam int SQ_W        = 2 * IN_W;         // a^2 + b^2
  localparam int ROOT_W      = SQ_W / 2 + ACC_FRAC;
  localparam int SQRT_STAGES = ROOT_W;           // one root bit per stage
  localparam int REM_W       = ROOT_W + 3;       // partial remainder
  localparam int CW          = 36;               // CORDIC x/y datapath
  localparam int ZW          = 25;               // CORDIC angle accumulator
  localparam int ATAN_W      = 22;
  localparam int TABLE_LEN   = 24;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [ATAN_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // one lane's finished angle
  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] angle;
  } lane_res_t;

endpackage

// File: rtl/atpr_sqrt.sv
// Pipelined floor square root, one result bit per stage, sideband carried along.
module atpr_sqrt (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [atpr_pkg::SQ_W-1:0]            in_sq,
  input  logic signed [atpr_pkg::NUM_W-1:0]    in_num,
  output logic                                 out_valid,
  output logic [atpr_pkg::ROOT_W-1:0]          out_root,
  output logic signed [atpr_pkg::NUM_W-1:0]    out_num
);

  localparam int N = atpr_pkg::SQRT_STAGES;

  logic                               vld_q  [N+1];
  logic [atpr_pkg::SQ_W-1:0]          sq_q   [N+1];
  logic signed [atpr_pkg::NUM_W-1:0]  num_q  [N+1];
  logic [atpr_pkg::REM_W-1:0]         rem_q  [N+1];
  logic [atpr_pkg::ROOT_W-1:0]        root_q [N+1];

  assign vld_q[0]  = in_valid;
  assign sq_q[0]   = in_sq;
  assign num_q[0]  = in_num;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_stage
    // radicand is in_sq followed by 2*ACC_FRAC zero bits; pair K from the top
    localparam int K = N - 1 - j;

    logic [1:0]                        pair;
    logic [atpr_pkg::REM_W-1:0]        rem_sh;
    logic [atpr_pkg::REM_W-1:0]        trial;
    logic                              vld_r;
    logic [atpr_pkg::SQ_W-1:0]         sq_r;
    logic signed [atpr_pkg::NUM_W-1:0] num_r;
    logic [atpr_pkg::REM_W-1:0]        rem_r;
    logic [atpr_pkg::ROOT_W-1:0]       root_r;

    if (K >= atpr_pkg::ACC_FRAC) begin : g_data
      assign pair = sq_q[j][2*(K-atpr_pkg::ACC_FRAC)+1 -: 2];
    end else begin : g_frac
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_q[j][atpr_pkg::REM_W-3:0], pair};
    assign trial  = {1'b0, root_q[j], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_q[j];
      end
    end

    always_ff @(posedge clk) begin
      sq_r  <= sq_q[j];
      num_r <= num_q[j];
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_q[j][atpr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_q[j][atpr_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    assign vld_q[j+1]  = vld_r;
    assign sq_q[j+1]   = sq_r;
    assign num_q[j+1]  = num_r;
    assign rem_q[j+1]  = rem_r;
    assign root_q[j+1] = root_r;
  end

  assign out_valid = vld_q[N];
  assign out_root  = root_q[N];
  assign out_num   = num_q[N];

endmodule

// File: rtl/atpr_cordic.sv
// Pipelined vectoring CORDIC in degrees, with rounding and clamping of the angle.
module atpr_cordic #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int STEPS           = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [atpr_pkg::ROOT_W-1:0]        in_root,
  input  logic signed [atpr_pkg::NUM_W-1:0]  in_num,
  output atpr_pkg::lane_res_t                out_res
);

  localparam int CW    = atpr_pkg::CW;
  localparam int ZW    = atpr_pkg::ZW;
  localparam int SHIFT = atpr_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int RND_I = 1 << (SHIFT - 1);
  localparam int LIM_I = 90 << ANGLE_FRAC_BITS;
  localparam int MAX_I = (1 << (atpr_pkg::OUT_W - 1)) - 1;

  localparam logic signed [ZW-1:0] RND     = ZW'(RND_I);
  localparam logic signed [ZW-1:0] LIM     = ZW'(LIM_I);
  localparam logic signed [ZW-1:0] NEG_LIM = ZW'(-LIM_I);
  localparam logic signed [ZW-1:0] MAX_A   = ZW'(MAX_I);
  localparam logic signed [ZW-1:0] MIN_A   = ZW'(-MAX_I - 1);

  logic                 vld_q  [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic signed [CW-1:0] x_q    [STEPS+1];
  logic signed [CW-1:0] y_q    [STEPS+1];
  logic signed [ZW-1:0] z_q    [STEPS+1];

  // load: x = magnitude, y = numerator scaled to the same fraction
  logic                 vld0_r;
  logic                 zero0_r;
  logic signed [CW-1:0] x0_r;
  logic signed [CW-1:0] y0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    zero0_r <= (in_num == '0);
    x0_r    <= $signed({{(CW-atpr_pkg::ROOT_W){1'b0}}, in_root});
    y0_r    <= $signed({{(CW-atpr_pkg::NUM_W-atpr_pkg::ACC_FRAC){in_num[atpr_pkg::NUM_W-1]}},
                        in_num, {atpr_pkg::ACC_FRAC{1'b0}}});
  end

  assign vld_q[0]  = vld0_r;
  assign zero_q[0] = zero0_r;
  assign x_q[0]    = x0_r;
  assign y_q[0]    = y0_r;
  assign z_q[0]    = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] atn;
    logic                 vld_r;
    logic                 zero_r;
    logic signed [CW-1:0] x_r;
    logic signed [CW-1:0] y_r;
    logic signed [ZW-1:0] z_r;

    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign atn = $signed({{(ZW-atpr_pkg::ATAN_W){1'b0}}, atpr_pkg::ATAN_Q16[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_q[i];
      end
    end

    // rotate toward y = 0
    always_ff @(posedge clk) begin
      zero_r <= zero_q[i];
      if (!y_q[i][CW-1]) begin
        x_r <= x_q[i] + dx;
        y_r <= y_q[i] - dy;
        z_r <= z_q[i] + atn;
      end else begin
        x_r <= x_q[i] - dx;
        y_r <= y_q[i] + dy;
        z_r <= z_q[i] - atn;
      end
    end

    assign vld_q[i+1]  = vld_r;
    assign zero_q[i+1] = zero_r;
    assign x_q[i+1]    = x_r;
    assign y_q[i+1]    = y_r;
    assign z_q[i+1]    = z_r;
  end

  // round half up, clamp to +/-90 deg, saturate to the output word
  logic signed [ZW-1:0]              z_rnd;
  logic signed [ZW-1:0]              ang;
  logic signed [ZW-1:0]              ang_cl;
  logic signed [ZW-1:0]              ang_sat;
  logic                              res_vld_r;
  logic signed [atpr_pkg::OUT_W-1:0] res_ang_r;
  atpr_pkg::lane_res_t               res_nxt;

  assign z_rnd = z_q[STEPS] + RND;
  assign ang   = z_rnd >>> SHIFT;

  always_comb begin
    priority if (ang > LIM) begin
      ang_cl = LIM;
    end else if (ang < NEG_LIM) begin
      ang_cl = NEG_LIM;
    end else begin
      ang_cl = ang;
    end
    priority if (ang_cl > MAX_A) begin
      ang_sat = MAX_A;
    end else if (ang_cl < MIN_A) begin
      ang_sat = MIN_A;
    end else begin
      ang_sat = ang_cl;
    end
    res_nxt.valid = vld_q[STEPS];
    res_nxt.angle = zero_q[STEPS] ? '0 : ang_sat[atpr_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_ang_r <= res_nxt.angle;
  end

  assign out_res = '{valid: res_vld_r, angle: res_ang_r};

endmodule

// File: rtl/atpr_lane.sv
// One angle lane: sum of squares, square root and CORDIC.
module atpr_lane #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int STEPS           = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [atpr_pkg::NUM_W-1:0]  in_num,
  input  logic signed [atpr_pkg::IN_W-1:0]   in_a,
  input  logic signed [atpr_pkg::IN_W-1:0]   in_b,
  output atpr_pkg::lane_res_t                out_res
);

  logic signed [atpr_pkg::SQ_W-1:0]  prod_a;
  logic signed [atpr_pkg::SQ_W-1:0]  prod_b;
  logic                              vld1_r;
  logic                              vld2_r;
  logic signed [atpr_pkg::NUM_W-1:0] num1_r;
  logic signed [atpr_pkg::NUM_W-1:0] num2_r;
  logic [atpr_pkg::SQ_W-1:0]         a2_r;
  logic [atpr_pkg::SQ_W-1:0]         b2_r;
  logic [atpr_pkg::SQ_W-1:0]         sum_r;
  logic                              sq_vld;
  logic [atpr_pkg::ROOT_W-1:0]       sq_root;
  logic signed [atpr_pkg::NUM_W-1:0] sq_num;

  assign prod_a = in_a * in_a;
  assign prod_b = in_b * in_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  // squares are never negative; sum stays below 2^31 + 1
  always_ff @(posedge clk) begin
    a2_r   <= prod_a;
    b2_r   <= prod_b;
    num1_r <= in_num;
    sum_r  <= a2_r + b2_r;
    num2_r <= num1_r;
  end

  atpr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld2_r),
    .in_sq     (sum_r),
    .in_num    (num2_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_num   (sq_num)
  );

  atpr_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .STEPS           (STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_vld),
    .in_root  (sq_root),
    .in_num   (sq_num),
    .out_res  (out_res)
  );

endmodule

// File: rtl/atpr_merge.sv
// Joins the pitch and roll lanes into one registered result word.
`include "assert_macros.svh"

module atpr_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  atpr_pkg::lane_res_t                 in_pitch,
  input  atpr_pkg::lane_res_t                 in_roll,
  output logic                                out_valid,
  output logic signed [atpr_pkg::OUT_W-1:0]   out_pitch_angle,
  output logic signed [atpr_pkg::OUT_W-1:0]   out_roll_angle
);

  logic                              valid_r;
  logic signed [atpr_pkg::OUT_W-1:0] pitch_r;
  logic signed [atpr_pkg::OUT_W-1:0] roll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_pitch.valid & in_roll.valid;
    end
  end

  always_ff @(posedge clk) begin
    pitch_r <= in_pitch.angle;
    roll_r  <= in_roll.angle;
  end

  assign out_valid       = valid_r;
  assign out_pitch_angle = pitch_r;
  assign out_roll_angle  = roll_r;

  // both lanes have the same depth, so their words must line up
  `ATPR_ASSERT(a_lanes_lockstep, 1'b1, in_pitch.valid == in_roll.valid, "lanes out of step")

endmodule

// File: rtl/accel_tilt_pitch_roll.sv
// Top level of the accelerometer pitch/roll tilt block.
//
// Takes one signed three-axis accelerometer word (x, y, z raw counts) and
// returns pitch = atan2(-x, sqrt(y^2+z^2)) and roll = atan2(y, sqrt(x^2+z^2))
// in degrees times 2^ANGLE_FRAC_BITS, rounded half up and clamped to +/-90
// degrees (and to the 16-bit word). A zero numerator gives exactly 0.
// A new word is taken on every clock edge with start high and busy low; busy
// is high only while rst_n is held, so the block takes one word per cycle.
// Each result appears on out_pitch_angle / out_roll_angle for exactly one
// cycle with out_valid high. The receiver cannot stall: a result not taken
// in that cycle is gone. Each result passes through the two lanes, each
// with a square register and a sum register, a 32-stage bit-per-stage
// square root, one CORDIC load stage, one stage per CORDIC step (steps
// capped at 24) and an angle rounding stage, and then through the final
// merge register.
`include "assert_macros.svh"

module accel_tilt_pitch_roll #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [atpr_pkg::IN_W-1:0]    in_accel_x,
  input  logic signed [atpr_pkg::IN_W-1:0]    in_accel_y,
  input  logic signed [atpr_pkg::IN_W-1:0]    in_accel_z,
  output logic                                out_valid,
  output logic signed [atpr_pkg::OUT_W-1:0]   out_pitch_angle,
  output logic signed [atpr_pkg::OUT_W-1:0]   out_roll_angle
);

  // table holds 24 entries; more steps add nothing
  localparam int STEPS = (CORDIC_STEPS > atpr_pkg::TABLE_LEN) ? atpr_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;
  localparam int LATENCY = atpr_pkg::SQRT_STAGES + STEPS + 5;
  localparam int LIM_RAW = 90 << ANGLE_FRAC_BITS;
  localparam int OUT_MAX = (1 << (atpr_pkg::OUT_W - 1)) - 1;
  localparam int ANG_LIM = (LIM_RAW > OUT_MAX) ? OUT_MAX : LIM_RAW;
  localparam int WARM_W  = $clog2(LATENCY + 1);

  logic                              accept;
  logic signed [atpr_pkg::NUM_W-1:0] num_pitch;
  logic signed [atpr_pkg::NUM_W-1:0] num_roll;
  atpr_pkg::lane_res_t               res_pitch;
  atpr_pkg::lane_res_t               res_roll;
  logic [WARM_W-1:0]                 warm_cnt_r;
  logic                              warm;
  logic                              angles_ok;

  // fully pipelined: only reset holds off new words
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // pitch numerator is -x; -(-32768) needs the extra bit
  assign num_pitch = -$signed({in_accel_x[atpr_pkg::IN_W-1], in_accel_x});
  assign num_roll  = $signed({in_accel_y[atpr_pkg::IN_W-1], in_accel_y});

  // pitch lane: -x against |(y, z)|
  atpr_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .STEPS           (STEPS)
  ) u_lane_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_num   (num_pitch),
    .in_a     (in_accel_y),
    .in_b     (in_accel_z),
    .out_res  (res_pitch)
  );

  // roll lane: y against |(x, z)|
  atpr_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .STEPS           (STEPS)
  ) u_lane_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_num   (num_roll),
    .in_a     (in_accel_x),
    .in_b     (in_accel_z),
    .out_res  (res_roll)
  );

  atpr_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_pitch        (res_pitch),
    .in_roll         (res_roll),
    .out_valid       (out_valid),
    .out_pitch_angle (out_pitch_angle),
    .out_roll_angle  (out_roll_angle)
  );

  // counts up from reset until it reaches LATENCY, so the latency check
  // only looks back over cycles that really happened
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else if (!warm) begin
      warm_cnt_r <= warm_cnt_r + 1'b1;
    end
  end

  assign warm = (warm_cnt_r == WARM_W'(LATENCY));

  assign angles_ok = (out_pitch_angle <= ANG_LIM) && (out_pitch_angle >= -ANG_LIM) &&
                     (out_roll_angle <= ANG_LIM) && (out_roll_angle >= -ANG_LIM);

  // one result per accepted word, at fixed latency
  `ATPR_ASSERT(a_fixed_latency, warm, out_valid == $past(accept, LATENCY), "result latency off")

  // zero x gives a level pitch
  `ATPR_ASSERT(a_pitch_zero, out_valid && ($past(in_accel_x, LATENCY) == '0), out_pitch_angle == '0, "pitch not zero")

  // both angles stay within +/-90 degrees
  `ATPR_ASSERT(a_angle_range, out_valid, angles_ok, "angle out of range")

endmodule
